// File: rtl/core/ppu_pkg.sv
//------------------------------------------------------------------------------
// ppu_pkg
// Shared types, command codes and the sine table of the particle pool.
//------------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

  localparam int unsigned Slots     = 64;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned AngleBits = 10;
  localparam int unsigned QuarterN  = 1 << (AngleBits - 2);

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ALPHA = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DAMP   = 2'd0,
    REG_WINDOW = 2'd1,
    REG_STEP   = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef logic signed [23:0] q24_t;

  // Quarter-wave sine in Q1.14 of quarter index q, from an integer Taylor
  // series in Q30. Evaluated at elaboration to fill the sine table.
  function automatic logic [14:0] sin_quarter(input int unsigned q);
    longint unsigned x, t;
    longint          sum;
    x   = (64'(q) * 64'd1686629713) >> (AngleBits - 2);
    t   = x;
    sum = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * k) * (2 * k + 1));
      if (k[0]) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > 64'sd16384) sum = 64'sd16384;
    return 15'(sum);
  endfunction

  function automatic q24_t sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) return 24'sh7FFFFF;
    if (v < -42'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ppu_mac.sv
//------------------------------------------------------------------------------
// ppu_mac
// Shared multiplier: registered 24 x 17 signed product with rounding shift.
//------------------------------------------------------------------------------
`default_nettype none

module ppu_mac (
  input  wire                 clk_i,
  input  wire  signed [23:0]  a_i,
  input  wire  signed [16:0]  b_i,
  input  wire                 shift16_i,
  output logic signed [41:0]  rnd_o
);
  import ppu_pkg::*;

  logic signed [40:0] prod_q;
  logic               s16_q;

  // One product per cycle, registered before rounding.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    s16_q  <= shift16_i;
  end

  // Round half up back to Q16.8.
  always_comb begin
    if (s16_q) rnd_o = (42'(prod_q) + 42'sd32768) >>> 16;
    else       rnd_o = (42'(prod_q) + 42'sd8192) >>> 14;
  end

endmodule

`default_nettype wire

// File: rtl/core/particle_pool_update.sv
//------------------------------------------------------------------------------
// particle_pool_update
// Particle pool with spawn, set-alpha and tick, sequenced over one multiplier.
//------------------------------------------------------------------------------
// Spawn scans the slots in order for a free one; set-alpha writes one slot's opacity.
// Tick visits each live slot: one shared multiplier does five
// products per slot over six phases, plus read, write, emit and return to the
// scan; each free slot is skipped in the scan. A stalled output register adds its
// wait. Reset clears the live bits and restores register values.
`default_nettype none

module particle_pool_update (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [1:0]             cmd_i,
  input  wire  [5:0]             slot_i,
  input  wire  signed [23:0]     start_x_i,
  input  wire  signed [23:0]     start_y_i,
  input  wire  signed [23:0]     start_z_i,
  input  wire  signed [23:0]     vel_x_i,
  input  wire  signed [23:0]     vel_y_i,
  input  wire  signed [23:0]     vel_z_i,
  input  wire  [9:0]             heading_i,
  input  wire  [15:0]            opacity_i,
  input  wire  [15:0]            lifetime_i,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [1:0]             cfg_index_i,
  input  wire  [15:0]            cfg_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [5:0]             out_slot_o,
  output logic signed [23:0]     out_x_o,
  output logic signed [23:0]     out_y_o,
  output logic signed [23:0]     out_z_o,
  output logic [15:0]            out_alpha_o,
  output logic                   alive_o,
  output logic                   pool_full_o,
  output logic                   last_o
);
  import ppu_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_WRITE = 8'b0001_0000,
    ST_EMIT  = 8'b0010_0000,
    ST_WAIT  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] damp_q, window_q, step_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q   <= 16'd983;
      window_q <= 16'd20;
      step_q   <= 16'd3277;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_DAMP:   damp_q   <= cfg_data_i;
        REG_WINDOW: window_q <= cfg_data_i;
        REG_STEP:   step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-slot storage, read one slot at a time into working registers.
  logic [Slots-1:0] live_q;
  q24_t px_m [Slots], py_m [Slots], pz_m [Slots];
  q24_t vx_m [Slots], vy_m [Slots], vz_m [Slots];
  logic [9:0]  hd_m [Slots];
  logic [15:0] al_m [Slots], lf_m [Slots];

  q24_t px_q, py_q, pz_q, vx_q, vy_q, vz_q;
  logic [9:0]  hd_q;
  logic [15:0] al_q, lf_q;
  logic [6:0]  idx_q;
  logic [2:0]  phase_q;
  logic [1:0]  cmd_q;
  logic        any_q;
  logic        wr_spawn, wr_tick, wr_alpha;
  logic        alive_q;

  // Captured input item.
  q24_t sx_q, sy_q, sz_q, svx_q, svy_q, svz_q;
  logic [9:0]  shd_q;
  logic [15:0] op_q, lt_q;
  logic [5:0]  slot_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sx_q <= start_x_i;  sy_q <= start_y_i;  sz_q <= start_z_i;
      svx_q <= vel_x_i;   svy_q <= vel_y_i;   svz_q <= vel_z_i;
      shd_q <= heading_i; op_q <= opacity_i;  lt_q <= lifetime_i;
      slot_q <= slot_i;
    end
  end

  // Memory writes and reads.
  always_ff @(posedge clk_i) begin
    if (wr_spawn) begin
      px_m[idx_q[5:0]] <= sx_q;  py_m[idx_q[5:0]] <= sy_q;  pz_m[idx_q[5:0]] <= sz_q;
      vx_m[idx_q[5:0]] <= svx_q; vy_m[idx_q[5:0]] <= svy_q; vz_m[idx_q[5:0]] <= svz_q;
      hd_m[idx_q[5:0]] <= shd_q; al_m[idx_q[5:0]] <= op_q;  lf_m[idx_q[5:0]] <= lt_q;
    end else if (wr_tick) begin
      px_m[idx_q[5:0]] <= px_q;  py_m[idx_q[5:0]] <= py_q;  pz_m[idx_q[5:0]] <= pz_q;
      vx_m[idx_q[5:0]] <= vx_q;  vy_m[idx_q[5:0]] <= vy_q;  vz_m[idx_q[5:0]] <= vz_q;
      al_m[idx_q[5:0]] <= al_q;  lf_m[idx_q[5:0]] <= lf_q;
    end else if (wr_alpha) begin
      al_m[slot_q] <= op_q;
    end
  end

  // Constant quarter-wave sine table, filled at elaboration.
  logic [14:0] sin_tab [QuarterN+1];
  for (genvar g = 0; g <= int'(QuarterN); g++) begin : g_sin
    localparam logic [14:0] SinVal = sin_quarter(g);
    assign sin_tab[g] = SinVal;
  end

  // Shared multiplier operand selection; phases 0..4 issue, 1..5 retire.
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic               mul_s16;
  logic signed [41:0] mul_r;
  logic signed [15:0] sin_v, cos_v;

  // Sine and cosine of the stored heading, folded into the first quarter.
  logic [AngleBits-1:0] cos_a;
  logic [8:0]           sin_r, cos_r;
  logic [14:0]          sin_m, cos_m;
  assign cos_a = hd_q + 10'(QuarterN);

  always_comb begin
    sin_r = {1'b0, hd_q[AngleBits-3:0]};
    if (hd_q[AngleBits-2]) sin_r = 9'(QuarterN) - sin_r;
    cos_r = {1'b0, cos_a[AngleBits-3:0]};
    if (cos_a[AngleBits-2]) cos_r = 9'(QuarterN) - cos_r;
    sin_m = sin_tab[sin_r];
    cos_m = sin_tab[cos_r];
    sin_v = hd_q[AngleBits-1] ? -$signed({1'b0, sin_m}) : $signed({1'b0, sin_m});
    cos_v = cos_a[AngleBits-1] ? -$signed({1'b0, cos_m}) : $signed({1'b0, cos_m});
  end

  always_comb begin
    mul_a = vx_q; mul_b = 17'(sin_v); mul_s16 = 1'b0;
    unique case (phase_q)
      3'd0: begin mul_a = vx_q; mul_b = 17'(sin_v); mul_s16 = 1'b0; end
      3'd1: begin mul_a = vz_q; mul_b = 17'(cos_v); mul_s16 = 1'b0; end
      3'd2: begin mul_a = vx_q; mul_b = $signed({1'b0, damp_q}); mul_s16 = 1'b1; end
      3'd3: begin mul_a = vy_q; mul_b = $signed({1'b0, damp_q}); mul_s16 = 1'b1; end
      3'd4: begin mul_a = vz_q; mul_b = $signed({1'b0, damp_q}); mul_s16 = 1'b1; end
      default: ;
    endcase
  end

  ppu_mac u_mac (
    .clk_i     (clk_i),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .shift16_i (mul_s16),
    .rnd_o     (mul_r)
  );

  // Output register.
  logic out_load;
  logic [5:0] o_slot;
  q24_t o_x, o_y, o_z;
  logic [15:0] o_alpha;
  logic o_alive, o_full, o_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (out_load) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_o <= o_slot; out_x_o <= o_x; out_y_o <= o_y; out_z_o <= o_z;
      out_alpha_o <= o_alpha; alive_o <= o_alive; pool_full_o <= o_full;
      last_o <= o_last;
    end
  end

  logic out_free;
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Next tick index over remaining slots: last live result check.
  logic more_live;
  always_comb begin
    more_live = 1'b0;
    for (int k = 0; k < Slots; k++)
      if (k > int'(idx_q) && live_q[k]) more_live = 1'b1;
  end

  // Sequencer.
  logic [15:0] lf_dec;
  assign lf_dec = lf_q - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      live_q  <= '0;
      idx_q   <= '0;
      phase_q <= '0;
      cmd_q   <= '0;
      any_q   <= 1'b0;
      alive_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: if (in_valid_i) begin
          cmd_q <= cmd_i; idx_q <= '0; any_q <= 1'b0;
        end
        // The index stays at the end of the pool until the next command resets it.
        ST_SCAN: if (idx_q != 7'(Slots)) begin
          if (cmd_q == CMD_SPAWN) begin
            if (!live_q[idx_q[5:0]] && out_free) live_q[idx_q[5:0]] <= 1'b1;
            else if (live_q[idx_q[5:0]]) idx_q <= idx_q + 7'd1;
          end else if (!live_q[idx_q[5:0]]) begin
            idx_q <= idx_q + 7'd1;
          end
        end
        ST_READ: begin
          phase_q <= '0; any_q <= 1'b1;
          px_q <= px_m[idx_q[5:0]]; py_q <= py_m[idx_q[5:0]]; pz_q <= pz_m[idx_q[5:0]];
          vx_q <= vx_m[idx_q[5:0]]; vy_q <= vy_m[idx_q[5:0]]; vz_q <= vz_m[idx_q[5:0]];
          hd_q <= hd_m[idx_q[5:0]]; al_q <= al_m[idx_q[5:0]]; lf_q <= lf_m[idx_q[5:0]];
        end
        ST_MUL: begin
          phase_q <= phase_q + 3'd1;
          unique case (phase_q)
            3'd1: px_q <= sat24(42'(px_q) - mul_r);
            3'd2: pz_q <= sat24(42'(pz_q) - mul_r);
            3'd3: begin
              vx_q <= sat24(42'(vx_q) - mul_r);
              py_q <= sat24(42'(py_q) - 42'(vy_q));
            end
            3'd4: vy_q <= sat24(42'(vy_q) - mul_r);
            3'd5: begin
              vz_q <= sat24(42'(vz_q) - mul_r);
              if (lf_q <= 16'd1) begin
                lf_q <= '0; alive_q <= 1'b0; live_q[idx_q[5:0]] <= 1'b0;
              end else begin
                lf_q <= lf_dec; alive_q <= 1'b1;
                if (lf_dec <= window_q)
                  al_q <= (al_q > step_q) ? al_q - step_q : 16'd0;
              end
            end
            default: ;
          endcase
        end
        ST_EMIT: if (out_free) idx_q <= idx_q + 7'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    wr_spawn = 1'b0; wr_tick = 1'b0; wr_alpha = 1'b0;
    o_slot = '0; o_x = '0; o_y = '0; o_z = '0; o_alpha = '0;
    o_alive = 1'b0; o_full = 1'b0; o_last = 1'b1;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        priority case (cmd_e'(cmd_i))
          CMD_SPAWN, CMD_TICK: state_d = ST_SCAN;
          CMD_ALPHA: state_d = ST_WAIT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (idx_q == 7'(Slots)) begin
          if (out_free) begin
            out_load = 1'b1;
            o_full = (cmd_q == CMD_SPAWN);
            state_d = ST_IDLE;
            if (cmd_q == CMD_TICK && any_q) out_load = 1'b0;
          end
        end else if (cmd_q == CMD_SPAWN) begin
          if (!live_q[idx_q[5:0]] && out_free) begin
            wr_spawn = 1'b1; out_load = 1'b1;
            o_slot = idx_q[5:0]; o_x = sx_q; o_y = sy_q; o_z = sz_q;
            o_alpha = op_q; o_alive = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (live_q[idx_q[5:0]]) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL: if (phase_q == 3'd5) state_d = ST_WRITE;
      ST_WRITE: begin
        wr_tick = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: if (out_free) begin
        out_load = 1'b1;
        o_slot = idx_q[5:0]; o_x = px_q; o_y = py_q; o_z = pz_q;
        o_alpha = al_q; o_alive = alive_q; o_last = !more_live;
        state_d = more_live ? ST_DONE : ST_IDLE;
      end
      ST_DONE: state_d = ST_SCAN;
      ST_WAIT: if (out_free) begin
        out_load = 1'b1; wr_alpha = 1'b1;
        o_slot = slot_q; o_alpha = op_q; o_alive = live_q[slot_q];
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A finished item always leaves the sequencer idle with the last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && o_last |=> state_q == ST_IDLE)
    else $error("last result without return to idle");

  // A spawn result always names a slot that is now live.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_spawn |=> live_q[$past(idx_q[5:0])])
    else $error("spawned slot not marked live");

  // Outputs are loaded only when the register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire
